### sv/lcdsw_pkg.sv
`default_nettype none

package lcdsw_pkg;

	localparam int unsigned OFFSET_W    = 17;
	localparam int unsigned DATA_W      = 16;
	localparam int unsigned INDEX_W     = 16;
	localparam int unsigned RGB_W       = 24;
	localparam int unsigned CYCLE_W     = 11;
	localparam int unsigned LINE_W      = 8;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned S_TDATA_W   = 40;
	localparam int unsigned S_TUSER_W   = 2;
	localparam int unsigned M_TDATA_W   = 56;
	localparam int unsigned M_TUSER_W   = 2;

	// first byte offset past the end of video memory
	localparam logic [OFFSET_W-1:0] VRAM_BYTES = 17'd98303;
	localparam logic [DATA_W-1:0]   DISPCNT_OK = 16'h0403;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_VRAM_WRITE,
		OP_DISPCNT_WRITE,
		OP_LINE_READ
	} opcode_t;

	typedef enum logic [1:0] {
		PH_VISIBLE,
		PH_HBLANK,
		PH_VBLANK
	} phase_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VISIBLE_CYCLES,
		REG_HBLANK_CYCLES,
		REG_VBL_CYCLES,
		REG_ACTIVE_ROWS,
		REG_FRAME_ROWS
	} reg_index_t;

	typedef struct packed {
		logic [CYCLE_W-1:0] visible_cycles;
		logic [CYCLE_W-1:0] hblank_cycles;
		logic [CYCLE_W-1:0] vbl_cycles;
		logic [LINE_W-1:0]  active_rows;
		logic [LINE_W-1:0]  frame_rows;
	} scan_cfg_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		phase_t            phase;
	} scan_status_t;

	// floor(c * 255 / 31) = 8c + floor(7c / 31), the second term by thresholds
	function automatic logic [7:0] scale5to8(input logic [4:0] c);
		logic [2:0] frac;
		frac = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
			+ 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
		return {c, 3'b000} + {5'b00000, frac};
	endfunction

endpackage

`default_nettype wire

### sv/lcdsw_scan.sv
`default_nettype none

module lcdsw_scan (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lcdsw_pkg::scan_cfg_t    cfg,
	input  wire                     tick,
	output lcdsw_pkg::scan_status_t next_status
);
	import lcdsw_pkg::*;

	phase_t              phase_q, phase_d;
	logic [CYCLE_W-1:0]  cycle_q, cycle_d;
	logic [LINE_W-1:0]   line_q, line_d;
	logic [CYCLE_W-1:0]  cycle_inc;
	logic [LINE_W-1:0]   line_inc;

	assign cycle_inc = cycle_q + 11'd1;
	assign line_inc  = line_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VISIBLE;
			cycle_q <= '0;
			line_q  <= '0;
		end else if (tick) begin
			phase_q <= phase_d;
			cycle_q <= cycle_d;
			line_q  <= line_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cycle_d = cycle_inc;
		line_d  = line_q;
		case (phase_q)
			PH_VISIBLE: begin
				if (cycle_inc >= cfg.visible_cycles) begin
					cycle_d = '0;
					phase_d = PH_HBLANK;
				end
			end
			PH_HBLANK: begin
				if (cycle_inc >= cfg.hblank_cycles) begin
					cycle_d = '0;
					line_d  = line_inc;
					phase_d = (line_inc == cfg.active_rows) ? PH_VBLANK : PH_VISIBLE;
				end
			end
			default: begin
				// vertical blank: count whole lines until the frame ends
				if (cycle_inc >= cfg.vbl_cycles) begin
					cycle_d = '0;
					line_d  = line_inc;
					if (line_inc >= cfg.frame_rows) begin
						line_d  = '0;
						phase_d = PH_VISIBLE;
					end
				end
			end
		endcase
	end

	always_comb begin
		if (tick) begin
			next_status.line  = line_d;
			next_status.phase = phase_d;
		end else begin
			next_status.line  = line_q;
			next_status.phase = phase_q;
		end
	end

endmodule

`default_nettype wire

### sv/lcdsw_pixel.sv
`default_nettype none

module lcdsw_pixel (
	input  wire [lcdsw_pkg::OFFSET_W-1:0] mem_offset,
	input  wire [lcdsw_pkg::DATA_W-1:0]   write_data,
	output logic                          in_range,
	output logic [lcdsw_pkg::INDEX_W-1:0] pixel_index,
	output logic [lcdsw_pkg::RGB_W-1:0]   pixel_rgb
);
	import lcdsw_pkg::*;

	assign in_range    = mem_offset < VRAM_BYTES;
	assign pixel_index = mem_offset[OFFSET_W-1:1];
	// bgr555: red low, blue high, top bit ignored
	assign pixel_rgb   = {scale5to8(write_data[4:0]), scale5to8(write_data[9:5]),
		scale5to8(write_data[14:10])};

endmodule

`default_nettype wire

### sv/lcd_scan_timing_and_vram_writer.sv
// LCD scan timing and video memory writer. Each input transaction (tick, video memory
// write, display control write or line read) yields exactly one result transaction.
// The block takes one item per clock cycle sustained while m_tready keeps the result
// register draining; each item passes the input register, then the result register.
// The rate is set by the update of the scan state: the cycle counter increment and
// compare against the phase limit, and the line step, are combinational and registered
// together, so each tick sees the state left by the one before it. Colour scaling is a
// small per-channel function with no iteration. Configuration writes are taken on every
// cycle and should be issued only while no item is in flight.
`default_nettype none

module lcd_scan_timing_and_vram_writer (
	input  wire                              clk,
	input  wire                              arst_n,
	// s_tdata: mem_offset[16:0], write_data[32:17], zero pad
	input  wire [lcdsw_pkg::S_TDATA_W-1:0]   s_tdata,
	// s_tuser: opcode[1:0]
	input  wire [lcdsw_pkg::S_TUSER_W-1:0]   s_tuser,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// m_tdata: pixel_index[15:0], pixel_rgb[39:16], line_number[47:40], phase[49:48], pad
	output logic [lcdsw_pkg::M_TDATA_W-1:0]  m_tdata,
	// m_tuser: pixel_valid[0], error[1]
	output logic [lcdsw_pkg::M_TUSER_W-1:0]  m_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [lcdsw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [lcdsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lcdsw_pkg::*;

	scan_cfg_t           cfg_q;
	scan_status_t        next_status;

	logic                s1_valid;
	opcode_t             opcode_s1;
	logic [OFFSET_W-1:0] offset_s1;
	logic [DATA_W-1:0]   wdata_s1;

	logic                advance;
	logic                scan_tick;
	logic                in_range;
	logic [INDEX_W-1:0]  index_raw;
	logic [RGB_W-1:0]    rgb_raw;
	logic                pix_valid;
	logic                err;

	logic                m_valid_q;
	logic                pix_valid_q;
	logic                err_q;
	logic [INDEX_W-1:0]  index_q;
	logic [RGB_W-1:0]    rgb_q;
	scan_status_t        status_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.visible_cycles <= 11'd960;
			cfg_q.hblank_cycles  <= 11'd272;
			cfg_q.vbl_cycles     <= 11'd1232;
			cfg_q.active_rows    <= 8'd160;
			cfg_q.frame_rows     <= 8'd228;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_VISIBLE_CYCLES: cfg_q.visible_cycles <= cfg_data;
				REG_HBLANK_CYCLES:  cfg_q.hblank_cycles  <= cfg_data;
				REG_VBL_CYCLES:     cfg_q.vbl_cycles     <= cfg_data;
				REG_ACTIVE_ROWS:    cfg_q.active_rows    <= cfg_data[LINE_W-1:0];
				REG_FRAME_ROWS:     cfg_q.frame_rows     <= cfg_data[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage moves on whenever the result register is free or being drained
	assign advance  = s1_valid && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid || !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1 <= opcode_t'(s_tuser[1:0]);
			offset_s1 <= s_tdata[16:0];
			wdata_s1  <= s_tdata[32:17];
		end
	end

	assign scan_tick = advance && (opcode_s1 == OP_TICK);

	lcdsw_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.tick        (scan_tick),
		.next_status (next_status)
	);

	lcdsw_pixel u_pixel (
		.mem_offset  (offset_s1),
		.write_data  (wdata_s1),
		.in_range    (in_range),
		.pixel_index (index_raw),
		.pixel_rgb   (rgb_raw)
	);

	assign pix_valid = (opcode_s1 == OP_VRAM_WRITE) && in_range;
	assign err = ((opcode_s1 == OP_VRAM_WRITE) && !in_range)
		|| ((opcode_s1 == OP_DISPCNT_WRITE) && (wdata_s1 != DISPCNT_OK));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_valid_q <= pix_valid;
			err_q       <= err;
			index_q     <= pix_valid ? index_raw : '0;
			rgb_q       <= pix_valid ? rgb_raw : '0;
			status_q    <= next_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = {err_q, pix_valid_q};
	assign m_tdata  = {6'b000000, status_q.phase, status_q.line, rgb_q, index_q};

`ifndef ASSERT_OFF
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> s1_valid)
		else $error("accepted transaction not held in input stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |=> s1_valid && $stable(opcode_s1) && $stable(offset_s1))
		else $error("input stage lost a stalled item");

	a_no_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !pix_valid_q |-> index_q == '0 && rgb_q == '0)
		else $error("non-pixel result carries pixel payload");

	a_excl_flags: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> !(pix_valid_q && err_q))
		else $error("pixel write flagged as error");
`endif

endmodule

`default_nettype wire

### sim/lcd_scan_timing_and_vram_writer_test.sv
`timescale 1ns / 1ps

module lcd_scan_timing_and_vram_writer_test;
	import lcdsw_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 120;

	typedef struct {
		opcode_t           op;
		logic [OFFSET_W-1:0] offset;
		logic [DATA_W-1:0]   data;
	} lcd_cmd_t;

	typedef struct packed {
		logic               pix_valid;
		logic [INDEX_W-1:0] pix_index;
		logic [RGB_W-1:0]   pix_rgb;
		logic [LINE_W-1:0]  line;
		logic [1:0]         phase;
		logic               err;
	} lcd_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic [S_TUSER_W-1:0]   s_tuser = '0;
	logic                   s_tvalid = 1'b0;
	wire                    s_tready;
	wire [M_TDATA_W-1:0]    m_tdata;
	wire [M_TUSER_W-1:0]    m_tuser;
	wire                    m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_valid = 1'b0;
	wire                    cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	lcd_scan_timing_and_vram_writer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// scan timing model
	scan_cfg_t           timing;
	phase_t              scan_ph;
	logic [CYCLE_W-1:0]  cycle_cnt;
	logic [LINE_W-1:0]   line_cnt;
	logic [DATA_W-1:0]   dispcnt;

	lcd_cmd_t            pending_cmds[$];
	lcd_result_t         awaited_results[$];
	lcd_cmd_t            tx_cmd;
	int                  items_queued = 0;
	int                  results_done = 0;
	int                  mismatches = 0;
	int                  n_ticks = 0, n_pixels = 0, n_rejects = 0, n_reads = 0;
	int                  n_frames = 0, n_wraps = 0;
	bit                  calm = 1'b0;
	bit                  in_acc = 1'b0, out_acc = 1'b0;
	int                  tx_wait = 0, rx_wait = 0, rx_count = 0;
	int                  idle_cycles = 0;

	function automatic logic [7:0] scale_channel(input logic [4:0] c);
		return 8'((32'(c) * 255) / 31);
	endfunction

	function automatic void advance_scan();
		cycle_cnt = cycle_cnt + 1'b1;
		case (scan_ph)
			PH_VISIBLE: begin
				if (cycle_cnt >= timing.visible_cycles) begin
					cycle_cnt = '0;
					scan_ph = PH_HBLANK;
				end
			end
			PH_HBLANK: begin
				if (cycle_cnt >= timing.hblank_cycles) begin
					cycle_cnt = '0;
					line_cnt = line_cnt + 1'b1;
					if (line_cnt == '0)
						n_wraps++;
					scan_ph = (line_cnt == timing.active_rows) ? PH_VBLANK : PH_VISIBLE;
				end
			end
			default: begin
				if (cycle_cnt >= timing.vbl_cycles) begin
					cycle_cnt = '0;
					line_cnt = line_cnt + 1'b1;
					if (line_cnt >= timing.frame_rows) begin
						line_cnt = '0;
						scan_ph = PH_VISIBLE;
						n_frames++;
					end
				end
			end
		endcase
	endfunction

	function automatic lcd_result_t predict_result(input opcode_t op,
			input logic [OFFSET_W-1:0] offset, input logic [DATA_W-1:0] data);
		lcd_result_t r;
		r = '0;
		case (op)
			OP_TICK: begin
				advance_scan();
				n_ticks++;
			end
			OP_VRAM_WRITE: begin
				if (offset < VRAM_BYTES) begin
					r.pix_valid = 1'b1;
					r.pix_index = offset[OFFSET_W-1:1];
					r.pix_rgb = {scale_channel(data[4:0]), scale_channel(data[9:5]),
						scale_channel(data[14:10])};
					n_pixels++;
				end else begin
					r.err = 1'b1;
					n_rejects++;
				end
			end
			OP_DISPCNT_WRITE: begin
				if (data == DISPCNT_OK) begin
					dispcnt = data;
				end else begin
					r.err = 1'b1;
					n_rejects++;
				end
			end
			default: n_reads++;
		endcase
		r.line = line_cnt;
		r.phase = scan_ph;
		return r;
	endfunction

	function automatic int idle_draw();
		if (calm)
			return 0;
		return int'($urandom_range(0, 19));
	endfunction

	// input transactions: predict, then check output transactions in order
	always @(posedge clk) begin
		lcd_result_t got, want;
		in_acc <= s_tvalid && s_tready;
		out_acc <= m_tvalid && m_tready;
		if (s_tvalid && s_tready)
			awaited_results.push_back(predict_result(opcode_t'(s_tuser), s_tdata[16:0],
				s_tdata[32:17]));
		if (m_tvalid && m_tready) begin
			results_done++;
			got = {m_tuser[0], m_tdata[15:0], m_tdata[39:16], m_tdata[47:40],
				m_tdata[49:48], m_tuser[1]};
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = awaited_results.pop_front();
				if (got.pix_valid !== want.pix_valid || got.pix_index !== want.pix_index
						|| got.pix_rgb !== want.pix_rgb || got.line !== want.line
						|| got.phase !== want.phase || got.err !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// sender
	always @(negedge clk) begin
		if (!s_tvalid || in_acc) begin
			if (tx_wait > 0) begin
				s_tvalid <= 1'b0;
				tx_wait--;
			end else if (pending_cmds.size() != 0) begin
				tx_cmd = pending_cmds.pop_front();
				s_tuser <= tx_cmd.op;
				s_tdata <= {7'd0, tx_cmd.data, tx_cmd.offset};
				s_tvalid <= 1'b1;
				tx_wait = idle_draw();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with two long hold-offs to back the block up
	always @(negedge clk) begin
		if (out_acc) begin
			rx_count++;
			if (rx_count == 150 || rx_count == 700)
				rx_wait = LONG_HOLD;
			else
				rx_wait = idle_draw();
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_VISIBLE_CYCLES: timing.visible_cycles = val;
			REG_HBLANK_CYCLES:  timing.hblank_cycles = val;
			REG_VBL_CYCLES:     timing.vbl_cycles = val;
			REG_ACTIVE_ROWS:    timing.active_rows = val[LINE_W-1:0];
			REG_FRAME_ROWS:     timing.frame_rows = val[LINE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_scan_regs(input int vis, input int hbl, input int lin,
			input int vis_lines, input int tot_lines);
		write_reg(REG_VISIBLE_CYCLES, 11'(vis));
		write_reg(REG_HBLANK_CYCLES, 11'(hbl));
		write_reg(REG_VBL_CYCLES, 11'(lin));
		write_reg(REG_ACTIVE_ROWS, 11'(vis_lines));
		write_reg(REG_FRAME_ROWS, 11'(tot_lines));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_cmd(input opcode_t op, input int offset, input int data);
		lcd_cmd_t c;
		c.op = op;
		c.offset = OFFSET_W'(offset);
		c.data = DATA_W'(data);
		pending_cmds.push_back(c);
		items_queued++;
	endtask

	task automatic queue_random(input int tick_pct);
		int r, k, off, dat;
		opcode_t op;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 9);
		if (r < tick_pct)
			op = OP_TICK;
		else if (k < 6)
			op = OP_VRAM_WRITE;
		else if (k < 8)
			op = OP_DISPCNT_WRITE;
		else
			op = OP_LINE_READ;
		k = $urandom_range(0, 9);
		if (k == 0)
			off = $urandom_range(VRAM_BYTES, 131071);
		else if (k == 1)
			case ($urandom_range(0, 3))
				0: off = 0;
				1: off = VRAM_BYTES - 1;
				2: off = VRAM_BYTES;
				default: off = 131071;
			endcase
		else
			off = $urandom_range(0, VRAM_BYTES - 1);
		dat = $urandom_range(0, 65535);
		if (op == OP_DISPCNT_WRITE && $urandom_range(0, 1) == 0)
			dat = DISPCNT_OK;
		queue_cmd(op, off, dat);
	endtask

	task automatic run_phase(input int n_lead_ticks, input int n_random, input int tick_pct,
			input bit quiet);
		calm = quiet;
		repeat (n_lead_ticks)
			queue_cmd(OP_TICK, $urandom_range(0, 131071), $urandom_range(0, 65535));
		repeat (n_random)
			queue_random(tick_pct);
		while (results_done != items_queued)
			@(negedge clk);
		repeat (6)
			@(posedge clk);
	endtask

	initial begin
		int lead;
		timing = '{visible_cycles: 11'd960, hblank_cycles: 11'd272, vbl_cycles: 11'd1232,
			active_rows: 8'd160, frame_rows: 8'd228};
		scan_ph = PH_VISIBLE;
		cycle_cnt = '0;
		line_cnt = '0;
		dispcnt = DISPCNT_OK;

		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: offset and colour extremes, odd offsets, control values
		queue_cmd(OP_LINE_READ, 0, 0);
		queue_cmd(OP_VRAM_WRITE, 0, 16'h0000);
		queue_cmd(OP_VRAM_WRITE, VRAM_BYTES - 1, 16'h7FFF);
		queue_cmd(OP_VRAM_WRITE, VRAM_BYTES - 2, 16'hFFFF);
		queue_cmd(OP_VRAM_WRITE, VRAM_BYTES, 16'h1234);
		queue_cmd(OP_VRAM_WRITE, 131071, 16'hFFFF);
		queue_cmd(OP_VRAM_WRITE, 1, 16'h8000);
		queue_cmd(OP_VRAM_WRITE, 2, 16'h001F);
		queue_cmd(OP_VRAM_WRITE, 4, 16'h03E0);
		queue_cmd(OP_VRAM_WRITE, 6, 16'h7C00);
		queue_cmd(OP_VRAM_WRITE, 8, 16'h2D25);
		queue_cmd(OP_DISPCNT_WRITE, 0, DISPCNT_OK);
		queue_cmd(OP_DISPCNT_WRITE, 0, 16'h0000);
		queue_cmd(OP_DISPCNT_WRITE, 0, 16'hFFFF);
		queue_cmd(OP_DISPCNT_WRITE, 0, 16'h0402);
		queue_cmd(OP_DISPCNT_WRITE, 131071, DISPCNT_OK);
		repeat (6)
			queue_cmd(OP_TICK, 0, 0);
		queue_cmd(OP_LINE_READ, 131071, 16'hFFFF);
		run_phase(0, 200, 50, 1'b0);

		// minimum timings: every cycle limit is reached on the first tick
		load_scan_regs(1, 1, 1, 3, 5);
		run_phase(0, 100, 70, 1'b1);

		// maximum timings: counter climbs well into the visible part
		load_scan_regs(2047, 2047, 2047, 255, 255);
		run_phase(0, 120, 90, 1'b0);

		// limits drop below the running count
		load_scan_regs(5, 3, 4, 2, 4);
		run_phase(0, 200, 70, 1'b1);

		// frame shorter than the visible area
		load_scan_regs(1, 1, 1, 255, 2);
		run_phase(0, 150, 90, 1'b0);

		// visible line limit behind the current line: counter runs through 255 and wraps
		load_scan_regs(1, 1, 1, 1, 3);
		lead = (scan_ph != PH_VBLANK) ? 2 * (256 - int'(line_cnt)) + 4 : 0;
		run_phase(lead, 150, 60, 1'b1);

		repeat (10)
			@(posedge clk);
		$display("run covered %0d transactions: %0d ticks, %0d pixel writes, %0d rejects, %0d reads",
			items_queued, n_ticks, n_pixels, n_rejects, n_reads);
		$display("scan passed %0d frame ends and %0d line counter wraps; %0d mismatches",
			n_frames, n_wraps, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (awaited_results.size() != 0)
				$display("%0d expected results never arrived", awaited_results.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
